### rtl/plti_pkg.sv
// ----------------------------------------------------------------------------
// plti_pkg
// Types and constants shared by the piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

	localparam int WORD_W      = 32;
	localparam int CFG_W       = 7;
	localparam int IDX_W       = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_AW        = 2;
	localparam int DIV_STEPS   = 64;
	localparam int DIV_CW      = 6;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                     operation;
		logic [IDX_W-1:0]         entry_index;
		logic signed [WORD_W-1:0] entry_x;
		logic signed [WORD_W-1:0] entry_fx;
		logic signed [WORD_W-1:0] query_point;
	} in_word_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     empty_table;
	} out_word_t;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_QUERY,
		KIND_EMPTY
	} kind_t;

	// one classified word on its way from front to back
	typedef struct packed {
		kind_t                    kind;
		logic [IDX_W-1:0]         index;
		logic signed [WORD_W-1:0] arg_x;   // entry x, or query point
		logic signed [WORD_W-1:0] arg_fx;
		logic [CFG_W-1:0]         count;   // entries in use, clamped to depth
	} task_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DIFF,
		ST_ABS,
		ST_MUL,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_SUM
	} back_state_t;

endpackage

### rtl/plti_div.sv
// ----------------------------------------------------------------------------
// plti_div
// Unsigned 64 by 32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plti_div import plti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*WORD_W-1:0]   dividend,
	input  logic [WORD_W-1:0]     divisor,
	output div_stat_t             stat,
	output logic [2*WORD_W-1:0]   quotient
);

	logic [WORD_W-1:0]   rem_q;
	logic [WORD_W-1:0]   dsr_q;
	logic [2*WORD_W-1:0] dvd_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [WORD_W:0]     rem_sh;
	logic                ge;
	logic [WORD_W:0]     rem_sub;

	assign rem_sh  = {rem_q, dvd_q[2*WORD_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
			dvd_q <= {dvd_q[2*WORD_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

### rtl/plti_queue.sv
// ----------------------------------------------------------------------------
// plti_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module plti_queue import plti_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  task_t wr_task,
	input  logic  rd,
	output task_t rd_task,
	output logic  q_full,
	output logic  q_empty
);

	task_t           slot_q [QUEUE_DEPTH];
	logic [Q_AW-1:0] wp_q;
	logic [Q_AW-1:0] rp_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign q_full  = cnt_q == (Q_AW+1)'(QUEUE_DEPTH);
	assign q_empty = cnt_q == '0;
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_task = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wp_q] <= wr_task;
	end

endmodule

### rtl/plti_front.sv
// ----------------------------------------------------------------------------
// plti_front
// Holds the entry count register, accepts words and classifies them.
// ----------------------------------------------------------------------------
module plti_front import plti_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             cfg_ready,
	input  logic             push,
	input  in_word_t         item,
	output logic             full,
	input  logic             q_full,
	output logic             q_wr,
	output task_t            q_task
);

	logic [CFG_W-1:0] entries_q;
	logic [CFG_W-1:0] n_eff;
	logic             idx_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) entries_q <= '0;
		else if (cfg_valid) entries_q <= cfg_data;
	end

	always_comb begin
		// count above the depth searches the whole table
		if (int'(entries_q) > TABLE_DEPTH) n_eff = CFG_W'(TABLE_DEPTH);
		else n_eff = entries_q;
		idx_ok = int'(item.entry_index) < TABLE_DEPTH;

		q_task.index  = item.entry_index;
		q_task.arg_fx = item.entry_fx;
		q_task.count  = n_eff;
		if (item.operation == OP_WRITE) begin
			q_task.kind  = KIND_WRITE;
			q_task.arg_x = item.entry_x;
		end else begin
			q_task.kind  = (n_eff == '0) ? KIND_EMPTY : KIND_QUERY;
			q_task.arg_x = item.query_point;
		end
	end

	assign full = q_full;
	// writes beyond the table are dropped here
	assign q_wr = push && !q_full && (item.operation == OP_QUERY || idx_ok);

endmodule

### rtl/plti_back.sv
// ----------------------------------------------------------------------------
// plti_back
// Table memory, sequential scan, interpolation datapath and result register.
// ----------------------------------------------------------------------------
module plti_back import plti_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  task_t     q_task,
	output logic      q_rd,
	output logic      empty,
	input  logic      pop,
	output out_word_t result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic signed [WORD_W+2:0] SAT_HI = {3'b000, 1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W+2:0] SAT_LO = {3'b111, 1'b1, {(WORD_W-1){1'b0}}};

	logic [WORD_W-1:0] mem_x [TABLE_DEPTH];
	logic [WORD_W-1:0] mem_f [TABLE_DEPTH];

	back_state_t              state_q, state_d;
	logic [CW-1:0]            idx_q, n_q;
	logic signed [WORD_W-1:0] qp_q, prev_x_q, prev_f_q, x_rd_q, f_rd_q;
	logic signed [WORD_W:0]   df_q, dq_q, dx_q;
	logic [WORD_W-1:0]        mdf_q, mdq_q, mdx_q;
	logic                     neg_q;
	logic [2*WORD_W-1:0]      prod_q;
	logic                     out_valid_q;
	out_word_t                out_q;

	logic                     wr_en, rd_en, div_start, res_load, lt, hit, last;
	out_word_t                res_d;
	div_stat_t                div_stat;
	logic [2*WORD_W-1:0]      quo;
	logic signed [WORD_W+2:0] base, mag, sum;
	logic                     big;
	logic signed [WORD_W-1:0] sat;

	plti_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (mdx_q),
		.stat     (div_stat),
		.quotient (quo)
	);

	assign lt   = x_rd_q < qp_q;
	assign hit  = (idx_q == '0) || (x_rd_q == qp_q) || (x_rd_q == prev_x_q);
	assign last = CW'(idx_q + 1'b1) == n_q;

	// final add with saturation; a quotient of 2^33 or more saturates on any base
	always_comb begin
		base = {{3{prev_f_q[WORD_W-1]}}, prev_f_q};
		mag  = {2'b00, quo[WORD_W:0]};
		sum  = neg_q ? base - mag : base + mag;
		big  = |quo[2*WORD_W-1:WORD_W+1];
		priority if (big) sat = neg_q ? SAT_LO[WORD_W-1:0] : SAT_HI[WORD_W-1:0];
		else if (sum > SAT_HI) sat = SAT_HI[WORD_W-1:0];
		else if (sum < SAT_LO) sat = SAT_LO[WORD_W-1:0];
		else sat = sum[WORD_W-1:0];
	end

	always_comb begin
		state_d   = state_q;
		q_rd      = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		res_load  = 1'b0;
		res_d     = '{value: f_rd_q, empty_table: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty && (q_task.kind == KIND_WRITE || !out_valid_q)) begin
					q_rd = 1'b1;
					unique case (q_task.kind)
						KIND_WRITE: wr_en = 1'b1;
						KIND_EMPTY: begin
							res_load = 1'b1;
							res_d    = '{value: '0, empty_table: 1'b1};
						end
						KIND_QUERY: state_d = ST_READ;
						default: ;
					endcase
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (lt) begin
					if (last) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_READ;
					end
				end else if (hit) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF:      state_d = ST_ABS;
			ST_ABS:       state_d = ST_MUL;
			ST_MUL:       state_d = ST_DIV_START;
			ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT:  if (div_stat.done) state_d = ST_SUM;
			ST_SUM: begin
				res_load = 1'b1;
				res_d    = '{value: sat, empty_table: 1'b0};
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[AW'(q_task.index)] <= q_task.arg_x;
			mem_f[AW'(q_task.index)] <= q_task.arg_fx;
		end
		if (rd_en) begin
			x_rd_q <= mem_x[idx_q[AW-1:0]];
			f_rd_q <= mem_f[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) out_q <= res_d;
		unique case (state_q)
			ST_IDLE: begin
				idx_q <= '0;
				n_q   <= CW'(q_task.count);
				qp_q  <= q_task.arg_x;
			end
			ST_CMP: begin
				if (lt) begin
					prev_x_q <= x_rd_q;
					prev_f_q <= f_rd_q;
					idx_q    <= idx_q + 1'b1;
				end
			end
			ST_DIFF: begin
				df_q <= {f_rd_q[WORD_W-1], f_rd_q} - {prev_f_q[WORD_W-1], prev_f_q};
				dq_q <= {qp_q[WORD_W-1], qp_q} - {prev_x_q[WORD_W-1], prev_x_q};
				dx_q <= {x_rd_q[WORD_W-1], x_rd_q} - {prev_x_q[WORD_W-1], prev_x_q};
			end
			ST_ABS: begin
				mdf_q <= df_q[WORD_W] ? WORD_W'(-df_q) : df_q[WORD_W-1:0];
				mdq_q <= dq_q[WORD_W] ? WORD_W'(-dq_q) : dq_q[WORD_W-1:0];
				mdx_q <= dx_q[WORD_W] ? WORD_W'(-dx_q) : dx_q[WORD_W-1:0];
				neg_q <= df_q[WORD_W] ^ dq_q[WORD_W] ^ dx_q[WORD_W];
			end
			ST_MUL: prod_q <= mdf_q * mdq_q;
			default: ;
		endcase
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

### rtl/piecewise_linear_table_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Breakpoint table in signed Q16.16 with scan and linear interpolation.
// ----------------------------------------------------------------------------
//
//  channel   signals                        word
//  --------  -----------------------------  -------------------------------
//  input     push, full, item               table write or query
//  result    empty, pop, result             value and empty-table flag
//  config    cfg_valid, cfg_ready, cfg_data entries in use (always ready)
//
// A table write is done in the back end without leaving the idle state. A
// query leaves the queue and is scanned entry by entry up to the one where it
// stops (one memory read and one compare per entry). An interpolating query
// then passes the datapath states DIFF, ABS, MUL and DIV_START, waits on the
// serial divider and ends with one final add in SUM.
// Reset clears control state only; table contents are undefined until written.
// The four-word queue lets the front take words while the back is busy; the
// back holds a finished result until popped and starts no new query meanwhile.
//
module piecewise_linear_table_interpolator import plti_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             push,
	output logic             full,
	input  in_word_t         item,
	output logic             empty,
	input  logic             pop,
	output out_word_t        result
);

	// front to queue
	logic  q_wr;
	task_t q_in;
	// queue to back
	logic  q_rd;
	task_t q_out;
	logic  q_full;
	logic  q_empty;

	plti_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.push      (push),
		.item      (item),
		.full      (full),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_task    (q_in)
	);

	plti_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_task (q_in),
		.rd      (q_rd),
		.rd_task (q_out),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	plti_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_task  (q_out),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	// an empty-table result always carries zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.empty_table) |-> (result.value == '0))
		else $error("empty-table result with nonzero value");

	// queue count cannot be both full and empty
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue full and empty together");

	// every accepted query lands in the queue
	a_query_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && item.operation == OP_QUERY) |=> !q_empty)
		else $error("accepted query missing from queue");

endmodule
